// ===== src/complex_arithmetic_unit_assert.svh =====
// Assertion macros for the complex arithmetic unit.
// They expect clk_i and rst_ni to be visible where they are used.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// The consequent must hold in the cycle in which the antecedent holds.
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never hold outside reset.
`define CAU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== src/cau_pkg.sv =====
`default_nettype none

package cau_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int RES_W        = 33;
  localparam int PROD_W       = 2 * SAMPLE_W;
  localparam int ANG_FRAC     = 40;
  localparam int CORDIC_STEPS = 58;
  // The vector grows by the CORDIC gain to a little above 2^61, so the
  // datapath is 64 bits wide.
  localparam int CORDIC_W     = 64;
  localparam int CORDIC_SH    = 61 - SAMPLE_W;
  localparam int STEP_W       = 14 + ANG_FRAC;
  localparam int Z_W          = 17 + ANG_FRAC;
  localparam int PHASE_W      = 16;
  localparam int SQRT_STEPS   = SAMPLE_W;
  localparam int SQRT_IN_W    = 2 * SQRT_STEPS;
  localparam int SQRT_REM_W   = SQRT_STEPS + 2;
  localparam int LAT_LIN      = 2;
  localparam int LAT_CORDIC   = CORDIC_STEPS + 3;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_MUL_CONJ,
    OP_CONJ,
    OP_MAG_SQ,
    OP_MAG,
    OP_PHASE
  } op_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic signed [RES_W-1:0] re;
    logic signed [RES_W-1:0] im;
  } cplx_res_t;

  typedef struct packed {
    logic swap;
    logic xneg;
    logic yneg;
    logic zero;
  } cordic_flags_t;

  // Shift and subtract division, evaluated at elaboration only.
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) in Q62 by its series.
  function automatic logic [63:0] atan_recip(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    p   = udiv(64'd1 << 62, n);
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        t = udiv(p, 64'(2 * k + 1));
        if ((k % 2) == 0) sum = sum + t;
        else sum = sum - t;
        p = udiv(p, n * n);
      end
    end
    return sum;
  endfunction

  // atan(2^-i) in Q62, i at least one.
  function automatic logic [63:0] atan_pow2(input int i);
    logic [63:0] sum;
    logic [63:0] t;
    int          e;
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        t = udiv(64'd1 << (62 - e), 64'(2 * k + 1));
        if ((k % 2) == 0) sum = sum + t;
        else sum = sum - t;
      end
    end
    return sum;
  endfunction

  // Angle of CORDIC step i in binary angle units with ANG_FRAC fraction bits.
  function automatic logic [STEP_W-1:0] ang_step(input int i);
    logic [63:0] quarter;
    logic [63:0] r;
    logic [63:0] q;
    quarter = (atan_recip(64'd5) << 2) - atan_recip(64'd239);
    r       = '0;
    q       = '0;
    if (i == 0) begin
      q = 64'd1 << (13 + ANG_FRAC);
    end else begin
      r = atan_pow2(i);
      for (int b = 0; b < 13 + ANG_FRAC; b++) begin
        r = r << 1;
        q = q << 1;
        if (r >= quarter) begin
          r    = r - quarter;
          q[0] = 1'b1;
        end
      end
    end
    return q[STEP_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/complex_arithmetic_unit.sv =====
// Complex arithmetic unit.
// Input beats arrive on the s_axis channel: tuser carries the op code and
// tdata the operands a and b. Each accepted beat gives exactly one result
// beat on the m_axis channel, in order: res_re and res_im, 33-bit signed.
// Ops: add, sub, mul, mul by conjugate, conj, squared magnitude, magnitude
// (floor square root) and phase (atan2 of a, full circle 65536 units).
// The pipeline length is set by the phase path: after the input register
// that takes the beat come one fold stage, 58 CORDIC vectoring stages, two
// stages to unfold and round, and the output register. The other ops run
// in shorter paths and are delayed to the same length, so results always
// stay in input order. Throughput is one beat per cycle. The whole pipeline
// advances as one: when the output holds a beat that the receiver does not
// take, every stage holds and s_axis_tready_o falls, so nothing is lost or
// repeated. Reset clears all valid bits at once; the unit takes beats in
// the first cycle after reset is released.
`default_nettype none

`include "complex_arithmetic_unit_assert.svh"

module complex_arithmetic_unit
  import cau_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // a_re, a_im, b_re, b_im
  input  wire logic [2:0]  s_axis_tuser_i,   // op
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [71:0]      m_axis_tdata_o    // res_re, res_im, zero fill
);

  localparam int LIN_DLY = LAT_CORDIC - LAT_LIN;
  localparam int SQ_DLY  = LAT_CORDIC - LAT_LIN - SQRT_STEPS;

  logic                      en;
  logic [LAT_CORDIC:0]       vld_q;
  op_e                       op_q [LAT_CORDIC+1];
  sample_t                   a_re_q, a_im_q, b_re_q, b_im_q;
  cplx_res_t                 lin_res;
  cplx_res_t                 lin_dly_q [LIN_DLY];
  logic [SQRT_STEPS-1:0]     root;
  logic [SQRT_STEPS-1:0]     root_dly_q [SQ_DLY];
  logic signed [PHASE_W-1:0] phase;
  cplx_res_t                 res_d, res_q;
  op_e                       op_out_q;
  logic                      out_vld_q;

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[LAT_CORDIC-1:0], s_axis_tvalid_i};
      out_vld_q <= vld_q[LAT_CORDIC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q[0] <= op_e'(s_axis_tuser_i);
      a_re_q  <= s_axis_tdata_i[15:0];
      a_im_q  <= s_axis_tdata_i[31:16];
      b_re_q  <= s_axis_tdata_i[47:32];
      b_im_q  <= s_axis_tdata_i[63:48];
    end
  end

  for (genvar k = 1; k <= LAT_CORDIC; k++) begin : g_op_dly
    always_ff @(posedge clk_i) begin
      if (en) op_q[k] <= op_q[k-1];
    end
  end

  cau_lin u_lin (
    .clk_i  (clk_i),
    .en_i   (en),
    .op_i   (op_q[0]),
    .a_re_i (a_re_q),
    .a_im_i (a_im_q),
    .b_re_i (b_re_q),
    .b_im_i (b_im_q),
    .res_o  (lin_res)
  );

  // Squared magnitude is never negative and fits the radicand width.
  cau_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  (lin_res.re[SQRT_IN_W-1:0]),
    .root_o (root)
  );

  cau_cordic u_cordic (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (a_re_q),
    .y_i     (a_im_q),
    .phase_o (phase)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      lin_dly_q[0]  <= lin_res;
      root_dly_q[0] <= root;
    end
  end

  for (genvar k = 1; k < LIN_DLY; k++) begin : g_lin_dly
    always_ff @(posedge clk_i) begin
      if (en) lin_dly_q[k] <= lin_dly_q[k-1];
    end
  end

  for (genvar k = 1; k < SQ_DLY; k++) begin : g_root_dly
    always_ff @(posedge clk_i) begin
      if (en) root_dly_q[k] <= root_dly_q[k-1];
    end
  end

  always_comb begin
    unique case (op_q[LAT_CORDIC])
      OP_MAG: begin
        res_d.re = {{(RES_W - SQRT_STEPS){1'b0}}, root_dly_q[SQ_DLY-1]};
        res_d.im = '0;
      end
      OP_PHASE: begin
        res_d.re = {{(RES_W - PHASE_W){phase[PHASE_W-1]}}, phase};
        res_d.im = '0;
      end
      default: res_d = lin_dly_q[LIN_DLY-1];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q    <= res_d;
      op_out_q <= op_q[LAT_CORDIC];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'b0, res_q.im, res_q.re};

  `CAU_ASSERT_IMP(a_scalar_im_zero, out_vld_q && (op_out_q == OP_MAG_SQ || op_out_q == OP_MAG || op_out_q == OP_PHASE), res_q.im == '0, "scalar op gave a nonzero imaginary part")
  `CAU_ASSERT_IMP(a_mag_sq_sign, out_vld_q && op_out_q == OP_MAG_SQ, !res_q.re[RES_W-1], "squared magnitude is negative")
  `CAU_ASSERT_NEVER(a_mag_range, out_vld_q && op_out_q == OP_MAG && res_q.re[RES_W-1:SQRT_STEPS] != '0, "magnitude out of range")

endmodule

`default_nettype wire

// ===== src/cau_lin.sv =====
`default_nettype none

module cau_lin
  import cau_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      en_i,
  input  wire op_e       op_i,
  input  wire sample_t   a_re_i,
  input  wire sample_t   a_im_i,
  input  wire sample_t   b_re_i,
  input  wire sample_t   b_im_i,
  output cplx_res_t      res_o
);

  op_e                        op_q;
  logic signed [PROD_W-1:0]   p0_q, p1_q, p2_q, p3_q;
  logic signed [SAMPLE_W:0]   s_re_q, s_im_q;
  cplx_res_t                  res_q;

  sample_t                    mb_re, mb_im;
  logic signed [SAMPLE_W:0]   s_re_d, s_im_d;
  cplx_res_t                  res_d;

  // For the magnitude ops the multipliers square a instead of forming a times b.
  always_comb begin
    if (op_i == OP_MAG_SQ || op_i == OP_MAG) begin
      mb_re = a_re_i;
      mb_im = a_im_i;
    end else begin
      mb_re = b_re_i;
      mb_im = b_im_i;
    end
  end

  always_comb begin
    unique case (op_i)
      OP_ADD: begin
        s_re_d = (SAMPLE_W + 1)'(a_re_i) + (SAMPLE_W + 1)'(b_re_i);
        s_im_d = (SAMPLE_W + 1)'(a_im_i) + (SAMPLE_W + 1)'(b_im_i);
      end
      OP_SUB: begin
        s_re_d = (SAMPLE_W + 1)'(a_re_i) - (SAMPLE_W + 1)'(b_re_i);
        s_im_d = (SAMPLE_W + 1)'(a_im_i) - (SAMPLE_W + 1)'(b_im_i);
      end
      OP_CONJ: begin
        s_re_d = (SAMPLE_W + 1)'(a_re_i);
        s_im_d = -(SAMPLE_W + 1)'(a_im_i);
      end
      default: begin
        s_re_d = '0;
        s_im_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q   <= op_i;
      p0_q   <= a_re_i * mb_re;
      p1_q   <= a_im_i * mb_im;
      p2_q   <= a_re_i * mb_im;
      p3_q   <= a_im_i * mb_re;
      s_re_q <= s_re_d;
      s_im_q <= s_im_d;
    end
  end

  always_comb begin
    unique case (op_q)
      OP_ADD, OP_SUB, OP_CONJ: begin
        res_d.re = RES_W'(s_re_q);
        res_d.im = RES_W'(s_im_q);
      end
      OP_MUL: begin
        res_d.re = RES_W'(p0_q) - RES_W'(p1_q);
        res_d.im = RES_W'(p2_q) + RES_W'(p3_q);
      end
      OP_MUL_CONJ: begin
        res_d.re = RES_W'(p0_q) + RES_W'(p1_q);
        res_d.im = RES_W'(p3_q) - RES_W'(p2_q);
      end
      OP_MAG_SQ, OP_MAG: begin
        res_d.re = RES_W'(p0_q) + RES_W'(p1_q);
        res_d.im = '0;
      end
      OP_PHASE: begin
        res_d.re = '0;
        res_d.im = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== src/cau_isqrt.sv =====
`default_nettype none

module cau_isqrt
  import cau_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic [SQRT_IN_W-1:0]   val_i,
  output logic [SQRT_STEPS-1:0]       root_o
);

  logic [SQRT_REM_W-1:0]  rem_q  [SQRT_STEPS+1];
  logic [SQRT_STEPS-1:0]  root_q [SQRT_STEPS+1];
  logic [SQRT_IN_W-1:0]   rad_q  [SQRT_STEPS+1];

  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign rad_q[0]  = val_i;

  // One result bit per stage, two radicand bits brought down each time.
  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
    logic [SQRT_REM_W+1:0] part;
    logic [SQRT_REM_W+1:0] trial;
    logic                  fits;

    assign part  = {rem_q[g], rad_q[g][SQRT_IN_W-1 -: 2]};
    assign trial = (SQRT_REM_W + 2)'({root_q[g], 2'b01});
    assign fits  = part >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g+1]  <= fits ? SQRT_REM_W'(part - trial) : SQRT_REM_W'(part);
        root_q[g+1] <= {root_q[g][SQRT_STEPS-2:0], fits};
        rad_q[g+1]  <= {rad_q[g][SQRT_IN_W-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[SQRT_STEPS];

endmodule

`default_nettype wire

// ===== src/cau_cordic.sv =====
`default_nettype none

module cau_cordic
  import cau_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire sample_t              x_i,
  input  wire sample_t              y_i,
  output logic signed [PHASE_W-1:0] phase_o
);

  localparam logic [Z_W-1:0] K_QUARTER = Z_W'(1) << (14 + ANG_FRAC);
  localparam logic [Z_W-1:0] K_HALF    = Z_W'(1) << (15 + ANG_FRAC);
  localparam logic [Z_W-1:0] K_ROUND   = Z_W'(1) << (ANG_FRAC - 1);

  logic signed [CORDIC_W-1:0] x_q [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] y_q [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]      z_q [CORDIC_STEPS+1];
  cordic_flags_t              fl_q [CORDIC_STEPS+1];

  logic [SAMPLE_W:0]          ax, ay;
  cordic_flags_t              fl_d;
  logic [Z_W-1:0]             fold_d, fold_q, sum_d;
  cordic_flags_t              fold_fl_q;
  logic signed [PHASE_W-1:0]  phase_q;

  // Fold the operand into the first octant.
  always_comb begin
    ax      = x_i[SAMPLE_W-1] ? -(SAMPLE_W + 1)'(x_i) : (SAMPLE_W + 1)'(x_i);
    ay      = y_i[SAMPLE_W-1] ? -(SAMPLE_W + 1)'(y_i) : (SAMPLE_W + 1)'(y_i);
    fl_d.swap = ay > ax;
    fl_d.xneg = x_i[SAMPLE_W-1];
    fl_d.yneg = y_i[SAMPLE_W-1];
    fl_d.zero = (x_i == '0) && (y_i == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= CORDIC_W'(fl_d.swap ? ay : ax) <<< CORDIC_SH;
      y_q[0]  <= CORDIC_W'(fl_d.swap ? ax : ay) <<< CORDIC_SH;
      z_q[0]  <= '0;
      fl_q[0] <= fl_d;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    localparam logic [STEP_W-1:0] STEP = ang_step(g);
    logic signed [Z_W-1:0] step_z;
    logic                  up;

    assign step_z = {{(Z_W - STEP_W){1'b0}}, STEP};
    assign up     = !y_q[g][CORDIC_W-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (up) begin
          x_q[g+1] <= x_q[g] + (y_q[g] >>> g);
          y_q[g+1] <= y_q[g] - (x_q[g] >>> g);
          z_q[g+1] <= z_q[g] + step_z;
        end else begin
          x_q[g+1] <= x_q[g] - (y_q[g] >>> g);
          y_q[g+1] <= y_q[g] + (x_q[g] >>> g);
          z_q[g+1] <= z_q[g] - step_z;
        end
        fl_q[g+1] <= fl_q[g];
      end
    end
  end

  // Undo the octant fold; the arithmetic wraps, only the low angle bits matter.
  always_comb begin
    unique case ({fl_q[CORDIC_STEPS].swap, fl_q[CORDIC_STEPS].xneg})
      2'b00:   fold_d = z_q[CORDIC_STEPS];
      2'b10:   fold_d = K_QUARTER - z_q[CORDIC_STEPS];
      2'b01:   fold_d = K_HALF - z_q[CORDIC_STEPS];
      default: fold_d = K_QUARTER + z_q[CORDIC_STEPS];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fold_q    <= fold_d;
      fold_fl_q <= fl_q[CORDIC_STEPS];
    end
  end

  assign sum_d = fold_fl_q.yneg ? K_ROUND - fold_q : K_ROUND + fold_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phase_q <= fold_fl_q.zero ? '0 : sum_d[ANG_FRAC +: PHASE_W];
    end
  end

  assign phase_o = phase_q;

endmodule

`default_nettype wire
